[src/ffsa_pkg.sv]
// ----------------------------------------------------------------------------
// ffsa_pkg
// shared types and constants of the first-fit segment allocator
// ----------------------------------------------------------------------------
package ffsa_pkg;

    localparam int MAX_SEGMENTS_DEF = 64;
    localparam int HEAP_BYTES       = 65536;
    localparam int HEADER_BYTES     = 16;

    localparam int SIZE_W   = 17;
    localparam int HANDLE_W = 16;
    localparam int NEED_W   = 18;

    localparam logic [SIZE_W-1:0] HEAP_LIMIT_RST = 17'd65536;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OOM  = 2'd1;
    localparam logic [1:0] ST_BADH = 2'd2;

    typedef struct packed {
        logic [SIZE_W-1:0] start;
        logic [SIZE_W-1:0] size;
        logic              free;
    } seg_entry_t;

endpackage

[src/ffsa_ram.sv]
// ----------------------------------------------------------------------------
// ffsa_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module ffsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[src/first_fit_segment_allocator_core.sv]
// ----------------------------------------------------------------------------
// first_fit_segment_allocator_core
// first-fit heap allocator with split and coalescing over a segment table
// ----------------------------------------------------------------------------
// The segment table lives in one ram with a single read and a single write
// port; every request walks it one entry per cycle. The time from accept to the
// next accept grows with the entries searched plus the entries shifted, and it
// waits in S_DONE while a pending result is stalled; searched plus shifted never
// exceeds the segment count, and the walk is paced by that one read port. One
// request is processed at a time; a finished result waits in the output register
// while the next request is taken. The table needs no clearing after reset.
module first_fit_segment_allocator_core import ffsa_pkg::*; #(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                command,
    input  logic [SIZE_W-1:0]   request_size,
    input  logic [HANDLE_W-1:0] handle,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          status,
    output logic [HANDLE_W-1:0] segment_offset,
    output logic [SIZE_W-1:0]   granted_size,
    output logic [SIZE_W-1:0]   total_allocated,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [SIZE_W-1:0]   cfg_data
);

    localparam int IW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_SEGMENTS);
    localparam logic [CW-1:0] ONE_C = CW'(1);
    localparam logic [SIZE_W-1:0] HDR = SIZE_W'(HEADER_BYTES);
    localparam logic [SIZE_W-1:0] SPLIT_MIN = SIZE_W'(HEADER_BYTES + 4);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_SEARCH = 8'b0000_0010,
        S_MISS   = 8'b0000_0100,
        S_HIT    = 8'b0000_1000,
        S_MOVE   = 8'b0001_0000,
        S_FIXA   = 8'b0010_0000,
        S_FIXB   = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic cmd_reg, cmd_next;
    logic [NEED_W-1:0] need_reg, need_next;
    logic [HANDLE_W-1:0] handle_reg, handle_next;
    logic [SIZE_W-1:0] heap_limit_reg, heap_limit_next;
    logic [CW-1:0] count_reg, count_next;
    logic [SIZE_W-1:0] heap_top_reg, heap_top_next;
    logic [SIZE_W-1:0] alloc_reg, alloc_next;
    logic [CW-1:0] chk_reg, chk_next;
    seg_entry_t prev_reg, prev_next;
    seg_entry_t cur_reg, cur_next;
    logic [CW-1:0] mv_rd_reg, mv_rd_next;
    logic [CW-1:0] mv_cnt_reg, mv_cnt_next;
    logic [CW-1:0] mv_wa_reg, mv_wa_next;
    logic [1:0] mv_off_reg, mv_off_next;
    logic mv_up_reg, mv_up_next;
    logic mv_pend_reg, mv_pend_next;
    logic [IW-1:0] fixa_addr_reg, fixa_addr_next;
    seg_entry_t fixa_data_reg, fixa_data_next;
    logic fixa_wr_reg, fixa_wr_next;
    logic [IW-1:0] fixb_addr_reg, fixb_addr_next;
    seg_entry_t fixb_data_reg, fixb_data_next;
    logic fixb_wr_reg, fixb_wr_next;
    logic [1:0] res_status_reg, res_status_next;
    logic [HANDLE_W-1:0] res_offset_reg, res_offset_next;
    logic [SIZE_W-1:0] res_size_reg, res_size_next;
    logic out_valid_reg, out_valid_next;
    logic [1:0] status_reg, status_next;
    logic [HANDLE_W-1:0] offset_reg, offset_next;
    logic [SIZE_W-1:0] granted_reg, granted_next;
    logic [SIZE_W-1:0] total_reg, total_next;

    logic ram_we;
    logic [IW-1:0] ram_waddr;
    seg_entry_t ram_wdata;
    logic [IW-1:0] ram_raddr;
    seg_entry_t ram_rdata;

    logic [SIZE_W-1:0] limit;
    logic match;
    logic [SIZE_W-1:0] rest;
    logic split;
    logic merge_prev;
    logic merge_next;
    logic [CW-1:0] base_idx;
    logic [SIZE_W-1:0] base_start;
    logic [SIZE_W-1:0] base_size0;
    logic [SIZE_W-1:0] base_size;
    logic [1:0] removed;
    logic [CW-1:0] count_left;
    logic drop;
    logic [NEED_W:0] span;
    logic [NEED_W:0] room;
    logic append_fail;

    ffsa_ram #(
        .WIDTH ($bits(seg_entry_t)),
        .DEPTH (MAX_SEGMENTS)
    ) u_seg_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_stall        = (state_reg != S_IDLE);
    assign cfg_ready       = 1'b1;
    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign segment_offset  = offset_reg;
    assign granted_size    = granted_reg;
    assign total_allocated = total_reg;

    always_comb
    begin
        limit = (int'(heap_limit_reg) < HEAP_BYTES) ? heap_limit_reg : SIZE_W'(HEAP_BYTES);
        if (cmd_reg == CMD_FREE)
        begin
            match = (ram_rdata.start == {1'b0, handle_reg});
        end
        else
        begin
            match = ram_rdata.free && ({1'b0, ram_rdata.size} >= need_reg);
        end
        rest  = cur_reg.size - need_reg[SIZE_W-1:0];
        split = (rest >= SPLIT_MIN) && (count_reg < COUNT_MAX);
        merge_prev = (chk_reg != '0) && prev_reg.free;
        base_idx   = merge_prev ? (chk_reg - ONE_C) : chk_reg;
        base_start = merge_prev ? prev_reg.start : cur_reg.start;
        base_size0 = merge_prev ? (prev_reg.size + HDR + cur_reg.size) : cur_reg.size;
        merge_next = ((chk_reg + ONE_C) < count_reg) && ram_rdata.free;
        base_size  = merge_next ? (base_size0 + HDR + ram_rdata.size) : base_size0;
        removed    = {1'b0, merge_prev} + {1'b0, merge_next};
        count_left = count_reg - CW'(removed);
        drop       = ((base_idx + ONE_C) == count_left);
        span = (NEED_W + 1)'(HEADER_BYTES) + {1'b0, need_reg};
        room = {2'b00, limit} - {2'b00, heap_top_reg};
        append_fail = (count_reg >= COUNT_MAX) || (heap_top_reg > limit) || (span > room);
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        need_next       = need_reg;
        handle_next     = handle_reg;
        heap_limit_next = heap_limit_reg;
        count_next      = count_reg;
        heap_top_next   = heap_top_reg;
        alloc_next      = alloc_reg;
        chk_next        = chk_reg;
        prev_next       = prev_reg;
        cur_next        = cur_reg;
        mv_rd_next      = mv_rd_reg;
        mv_cnt_next     = mv_cnt_reg;
        mv_wa_next      = mv_wa_reg;
        mv_off_next     = mv_off_reg;
        mv_up_next      = mv_up_reg;
        mv_pend_next    = mv_pend_reg;
        fixa_addr_next  = fixa_addr_reg;
        fixa_data_next  = fixa_data_reg;
        fixa_wr_next    = fixa_wr_reg;
        fixb_addr_next  = fixb_addr_reg;
        fixb_data_next  = fixb_data_reg;
        fixb_wr_next    = fixb_wr_reg;
        res_status_next = res_status_reg;
        res_offset_next = res_offset_reg;
        res_size_next   = res_size_reg;
        out_valid_next  = out_valid_reg && out_stall;
        status_next     = status_reg;
        offset_next     = offset_reg;
        granted_next    = granted_reg;
        total_next      = total_reg;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = ram_rdata;
        ram_raddr       = '0;

        if (cfg_valid)
        begin
            heap_limit_next = cfg_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next        = command;
                    need_next       = ({1'b0, request_size} + NEED_W'(3)) & ~NEED_W'(3);
                    handle_next     = handle;
                    chk_next        = '0;
                    res_status_next = ST_OK;
                    res_offset_next = '0;
                    res_size_next   = '0;
                    fixa_wr_next    = 1'b0;
                    fixb_wr_next    = 1'b0;
                    mv_cnt_next     = '0;
                    mv_pend_next    = 1'b0;
                    state_next      = (count_reg == '0) ? S_MISS : S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                ram_raddr = IW'(chk_reg + ONE_C);
                if (match)
                begin
                    cur_next   = ram_rdata;
                    state_next = S_HIT;
                end
                else
                begin
                    prev_next = ram_rdata;
                    if ((chk_reg + ONE_C) == count_reg)
                    begin
                        state_next = S_MISS;
                    end
                    else
                    begin
                        chk_next = chk_reg + ONE_C;
                    end
                end
            end
            S_HIT:
            begin
                if (cmd_reg == CMD_ALLOC)
                begin
                    res_offset_next = cur_reg.start[HANDLE_W-1:0];
                    if (split)
                    begin
                        mv_up_next     = 1'b1;
                        mv_off_next    = 2'd1;
                        mv_rd_next     = count_reg - ONE_C;
                        mv_cnt_next    = count_reg - ONE_C - chk_reg;
                        fixa_wr_next   = 1'b1;
                        fixa_addr_next = IW'(chk_reg + ONE_C);
                        fixa_data_next = '{start: cur_reg.start + HDR + need_reg[SIZE_W-1:0],
                                           size: rest - HDR, free: 1'b1};
                        fixb_wr_next   = 1'b1;
                        fixb_addr_next = IW'(chk_reg);
                        fixb_data_next = '{start: cur_reg.start, size: need_reg[SIZE_W-1:0],
                                           free: 1'b0};
                        count_next     = count_reg + ONE_C;
                        res_size_next  = need_reg[SIZE_W-1:0];
                        alloc_next     = alloc_reg + need_reg[SIZE_W-1:0];
                    end
                    else
                    begin
                        fixa_wr_next   = 1'b1;
                        fixa_addr_next = IW'(chk_reg);
                        fixa_data_next = '{start: cur_reg.start, size: cur_reg.size, free: 1'b0};
                        res_size_next  = cur_reg.size;
                        alloc_next     = alloc_reg + cur_reg.size;
                    end
                    state_next = S_MOVE;
                end
                else if (cur_reg.free)
                begin
                    res_status_next = ST_BADH;
                    state_next      = S_DONE;
                end
                else
                begin
                    res_size_next = cur_reg.size;
                    alloc_next    = alloc_reg - cur_reg.size;
                    mv_up_next    = 1'b0;
                    mv_off_next   = removed;
                    mv_rd_next    = base_idx + ONE_C + CW'(removed);
                    if (drop)
                    begin
                        count_next    = count_left - ONE_C;
                        heap_top_next = base_start;
                    end
                    else
                    begin
                        count_next     = count_left;
                        fixa_wr_next   = 1'b1;
                        fixa_addr_next = IW'(base_idx);
                        fixa_data_next = '{start: base_start, size: base_size, free: 1'b1};
                        if (removed != 2'd0)
                        begin
                            mv_cnt_next = count_left - base_idx - ONE_C;
                        end
                    end
                    state_next = S_MOVE;
                end
            end
            S_MISS:
            begin
                if (cmd_reg == CMD_FREE)
                begin
                    res_status_next = ST_BADH;
                    state_next      = S_DONE;
                end
                else if (append_fail)
                begin
                    res_status_next = ST_OOM;
                    state_next      = S_DONE;
                end
                else
                begin
                    fixa_wr_next    = 1'b1;
                    fixa_addr_next  = IW'(count_reg);
                    fixa_data_next  = '{start: heap_top_reg, size: need_reg[SIZE_W-1:0],
                                        free: 1'b0};
                    count_next      = count_reg + ONE_C;
                    heap_top_next   = heap_top_reg + span[SIZE_W-1:0];
                    alloc_next      = alloc_reg + need_reg[SIZE_W-1:0];
                    res_offset_next = heap_top_reg[HANDLE_W-1:0];
                    res_size_next   = need_reg[SIZE_W-1:0];
                    state_next      = S_FIXA;
                end
            end
            S_MOVE:
            begin
                ram_we    = mv_pend_reg;
                ram_waddr = IW'(mv_wa_reg);
                ram_wdata = ram_rdata;
                ram_raddr = IW'(mv_rd_reg);
                if (mv_cnt_reg != '0)
                begin
                    mv_pend_next = 1'b1;
                    mv_wa_next   = mv_up_reg ? (mv_rd_reg + ONE_C)
                                             : (mv_rd_reg - CW'(mv_off_reg));
                    mv_rd_next   = mv_up_reg ? (mv_rd_reg - ONE_C) : (mv_rd_reg + ONE_C);
                    mv_cnt_next  = mv_cnt_reg - ONE_C;
                end
                else
                begin
                    mv_pend_next = 1'b0;
                    if (!mv_pend_reg)
                    begin
                        state_next = S_FIXA;
                    end
                end
            end
            S_FIXA:
            begin
                ram_we     = fixa_wr_reg;
                ram_waddr  = fixa_addr_reg;
                ram_wdata  = fixa_data_reg;
                state_next = fixb_wr_reg ? S_FIXB : S_DONE;
            end
            S_FIXB:
            begin
                ram_we     = 1'b1;
                ram_waddr  = fixb_addr_reg;
                ram_wdata  = fixb_data_reg;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    offset_next    = res_offset_reg;
                    granted_next   = res_size_reg;
                    total_next     = alloc_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            heap_limit_reg <= HEAP_LIMIT_RST;
            count_reg      <= '0;
            heap_top_reg   <= '0;
            alloc_reg      <= '0;
            out_valid_reg  <= 1'b0;
            mv_cnt_reg     <= '0;
            mv_pend_reg    <= 1'b0;
            fixa_wr_reg    <= 1'b0;
            fixb_wr_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            heap_limit_reg <= heap_limit_next;
            count_reg      <= count_next;
            heap_top_reg   <= heap_top_next;
            alloc_reg      <= alloc_next;
            out_valid_reg  <= out_valid_next;
            mv_cnt_reg     <= mv_cnt_next;
            mv_pend_reg    <= mv_pend_next;
            fixa_wr_reg    <= fixa_wr_next;
            fixb_wr_reg    <= fixb_wr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        need_reg       <= need_next;
        handle_reg     <= handle_next;
        chk_reg        <= chk_next;
        prev_reg       <= prev_next;
        cur_reg        <= cur_next;
        mv_rd_reg      <= mv_rd_next;
        mv_wa_reg      <= mv_wa_next;
        mv_off_reg     <= mv_off_next;
        mv_up_reg      <= mv_up_next;
        fixa_addr_reg  <= fixa_addr_next;
        fixa_data_reg  <= fixa_data_next;
        fixb_addr_reg  <= fixb_addr_next;
        fixb_data_reg  <= fixb_data_next;
        res_status_reg <= res_status_next;
        res_offset_reg <= res_offset_next;
        res_size_reg   <= res_size_next;
        status_reg     <= status_next;
        offset_reg     <= offset_next;
        granted_reg    <= granted_next;
        total_reg      <= total_next;
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_MAX)
        else $error("segment count above table depth");

    a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == '0 |-> heap_top_reg == '0)
        else $error("empty heap with nonzero top");

    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_valid_reg && out_stall) |=> state_reg == S_DONE)
        else $error("result loaded over a pending one");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != ST_OK) |-> (granted_reg == '0 && offset_reg == '0))
        else $error("failed request carries a grant");

endmodule
